// ===== rtl/lc3b_pkg.sv =====
// Package for the LC-3b execute unit: payload structs, opcodes, codes.
// No dependencies.
package lc3b_pkg;

	typedef enum logic [1:0] {
		OP_EXEC = 2'd0,
		OP_WRMEM = 2'd1,
		OP_RDMEM = 2'd2,
		OP_SETPC = 2'd3
	} oper_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_PRIV = 2'd1,
		ST_RSVD = 2'd2
	} status_t;

	localparam logic [3:0] OPC_BR = 4'd0;
	localparam logic [3:0] OPC_ADD = 4'd1;
	localparam logic [3:0] OPC_LDB = 4'd2;
	localparam logic [3:0] OPC_STB = 4'd3;
	localparam logic [3:0] OPC_JSR = 4'd4;
	localparam logic [3:0] OPC_AND = 4'd5;
	localparam logic [3:0] OPC_LDW = 4'd6;
	localparam logic [3:0] OPC_STW = 4'd7;
	localparam logic [3:0] OPC_RTI = 4'd8;
	localparam logic [3:0] OPC_XOR = 4'd9;
	localparam logic [3:0] OPC_RES_A = 4'd10;
	localparam logic [3:0] OPC_RES_B = 4'd11;
	localparam logic [3:0] OPC_JMP = 4'd12;
	localparam logic [3:0] OPC_SHF = 4'd13;
	localparam logic [3:0] OPC_LEA = 4'd14;
	localparam logic [3:0] OPC_TRAP = 4'd15;

	typedef struct packed {
		logic [1:0] operation;
		logic [15:0] instruction;
		logic [15:0] mem_address;
		logic [7:0] mem_data;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [15:0] new_pc;
		logic dest_written;
		logic [2:0] dest_index;
		logic [15:0] dest_value;
		logic cond_n;
		logic cond_z;
		logic cond_p;
		logic user_mode;
		logic [7:0] read_data;
	} rsp_t;

	// Execution states of the back end
	typedef enum logic [2:0] {
		EX_IDLE,
		EX_RD0,
		EX_RD1,
		EX_RD2,
		EX_RD3,
		EX_WR1,
		EX_DONE
	} ex_state_t;

	function automatic logic [15:0] sext(input logic [15:0] v, input int bits);
		logic [15:0] r;
		r = v;
		for (int i = 0; i < 16; i++) begin
			if (i >= bits) r[i] = v[bits-1];
		end
		return r;
	endfunction

endpackage

// ===== rtl/lc3b_queue.sv =====
// Front end: two-entry request queue between the input port and the executer.
// Depends on lc3b_pkg.
module lc3b_queue import lc3b_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_req,
	output logic out_valid,
	input  logic out_ready,
	output req_t out_req
);
	req_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_req = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	// Storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_req;
	end

	// Pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ===== rtl/lc3b_exec.sv =====
// Back end: architectural state, byte memory and instruction sequencer.
// Depends on lc3b_pkg.
module lc3b_exec import lc3b_pkg::*; #(
	parameter int MEM_BYTES = 65536
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);
	localparam int AW = $clog2(MEM_BYTES);

	logic [7:0] mem [MEM_BYTES];
	logic [15:0] rf_q [8];
	logic [15:0] pc_q, pc_d;
	logic [2:0] cc_q, cc_d;
	logic priv_q, priv_d;

	ex_state_t state_q, state_d;
	req_t cur_q;
	logic [15:0] ea_q, ea_d;
	logic [7:0] lo_q, lo_d;
	logic rti_ph_q, rti_ph_d;
	rsp_t wrk_q, wrk_d, done_rsp;
	logic [7:0] rdat;
	logic rsp_full_q, rsp_load, can_out;

	// Register file write port
	logic rf_we;
	logic [2:0] rf_wi;
	logic [15:0] rf_wd;

	// Memory port control
	logic mem_we;
	logic [15:0] mem_wa, mem_ra;
	logic [7:0] mem_wd;

	logic [3:0] opc;
	logic [2:0] dr, sr1;
	logic [15:0] ir, a, b, pc2, off6, off6w, off9, off9w, off11, off11w;
	logic [15:0] sh, alu, ldb, word;

	function automatic logic [2:0] nzp_of(input logic [15:0] v);
		return {v[15], v == 16'd0, !v[15] && v != 16'd0};
	endfunction

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa[AW-1:0]] <= mem_wd;
		rdat <= mem[mem_ra[AW-1:0]];
	end

	assign ir = cur_q.instruction;
	assign opc = ir[15:12];
	assign dr = ir[11:9];
	assign sr1 = ir[8:6];
	assign a = rf_q[sr1];
	assign b = ir[5] ? sext(ir, 5) : rf_q[ir[2:0]];
	assign pc2 = pc_q + 16'd2;
	assign off6 = sext(ir, 6);
	assign off6w = {off6[14:0], 1'b0};
	assign off9 = sext(ir, 9);
	assign off9w = {off9[14:0], 1'b0};
	assign off11 = sext(ir, 11);
	assign off11w = {off11[14:0], 1'b0};
	assign ldb = {{8{rdat[7]}}, rdat};
	assign word = {rdat, lo_q};

	// Shifter
	always_comb begin
		if (ir[4]) begin
			if (ir[5]) sh = $signed(a) >>> ir[3:0];
			else sh = a >> ir[3:0];
		end else begin
			sh = a << ir[3:0];
		end
	end

	// Combinational ALU ops and LEA
	always_comb begin
		case (opc)
			OPC_ADD: alu = a + b;
			OPC_AND: alu = a & b;
			OPC_XOR: alu = a ^ b;
			OPC_SHF: alu = sh;
			default: alu = pc2 + off9w;
		endcase
	end

	// Result accept for the output register
	assign can_out = !rsp_full_q || rsp_ready;
	assign rsp_valid = rsp_full_q;
	assign req_ready = (state_q == EX_IDLE);

	// Sequencer next state, memory addressing and state updates
	always_comb begin
		state_d = state_q;
		mem_we = 1'b0;
		mem_wa = ea_q;
		mem_wd = 8'd0;
		mem_ra = ea_q;
		pc_d = pc_q;
		cc_d = cc_q;
		priv_d = priv_q;
		rf_we = 1'b0;
		rf_wi = dr;
		rf_wd = 16'd0;
		wrk_d = wrk_q;
		ea_d = ea_q;
		lo_d = lo_q;
		rti_ph_d = rti_ph_q;
		rsp_load = 1'b0;
		case (state_q)
			EX_IDLE: if (req_valid) begin
				state_d = EX_RD0;
				rti_ph_d = 1'b0;
				wrk_d = '0;
			end
			EX_RD0: begin
				// decode: address memory for first byte
				state_d = EX_DONE;
				case (cur_q.operation)
					OP_WRMEM: begin
						mem_we = 1'b1; mem_wa = cur_q.mem_address; mem_wd = cur_q.mem_data;
					end
					OP_RDMEM: begin
						mem_ra = cur_q.mem_address; state_d = EX_RD1;
					end
					OP_SETPC: pc_d = cur_q.mem_address;
					OP_EXEC: begin
						pc_d = pc2;
						case (opc)
							OPC_BR: if ((dr & cc_q) != 3'd0) pc_d = pc2 + off9w;
							OPC_ADD, OPC_AND, OPC_XOR, OPC_SHF, OPC_LEA: begin
								rf_we = 1'b1;
								rf_wd = alu;
								cc_d = nzp_of(alu);
								wrk_d.dest_written = 1'b1;
								wrk_d.dest_index = dr;
								wrk_d.dest_value = alu;
							end
							OPC_LDB: begin mem_ra = a + off6; state_d = EX_RD1; end
							OPC_LDW: begin mem_ra = a + off6w; state_d = EX_RD1; end
							OPC_TRAP: begin
								mem_ra = {7'd0, ir[7:0], 1'b0}; state_d = EX_RD1;
							end
							OPC_RTI: begin
								if (priv_q) wrk_d.status = ST_PRIV;
								else begin
									mem_ra = rf_q[6]; state_d = EX_RD1;
								end
							end
							OPC_STB: begin
								mem_we = 1'b1; mem_wa = a + off6; mem_wd = rf_q[dr][7:0];
							end
							OPC_STW: begin
								mem_we = 1'b1; mem_wa = a + off6w; mem_wd = rf_q[dr][7:0];
								state_d = EX_WR1;
							end
							OPC_JSR: begin
								// target uses the old register value
								rf_we = 1'b1;
								rf_wi = 3'd7;
								rf_wd = pc2;
								pc_d = ir[11] ? pc2 + off11w : a;
								wrk_d.dest_written = 1'b1;
								wrk_d.dest_index = 3'd7;
								wrk_d.dest_value = pc2;
							end
							OPC_JMP: pc_d = a;
							OPC_RES_A, OPC_RES_B: wrk_d.status = ST_RSVD;
							default: ;
						endcase
					end
					default: ;
				endcase
				ea_d = mem_we ? mem_wa : mem_ra;
			end
			EX_WR1: begin
				mem_we = 1'b1; mem_wa = ea_q + 16'd1; mem_wd = rf_q[dr][15:8];
				state_d = EX_DONE;
			end
			EX_RD1: begin
				// first byte arrives; fetch next one if word access
				lo_d = rdat;
				mem_ra = ea_q + 16'd1;
				if (cur_q.operation == OP_RDMEM) begin
					wrk_d.read_data = rdat;
					state_d = EX_DONE;
				end else if (opc == OPC_LDB) begin
					rf_we = 1'b1;
					rf_wd = ldb;
					cc_d = nzp_of(ldb);
					wrk_d.dest_written = 1'b1;
					wrk_d.dest_index = dr;
					wrk_d.dest_value = ldb;
					state_d = EX_DONE;
				end else begin
					state_d = EX_RD2;
				end
			end
			EX_RD2: begin
				mem_ra = ea_q + 16'd2;
				state_d = EX_DONE;
				if (opc == OPC_RTI && rti_ph_q) begin
					// psr complete
					priv_d = rdat[7];
					cc_d = lo_q[2:0];
					rf_we = 1'b1;
					rf_wi = 3'd6;
					rf_wd = ea_q + 16'd4;
					wrk_d.dest_written = 1'b1;
					wrk_d.dest_index = 3'd6;
					wrk_d.dest_value = ea_q + 16'd4;
				end else if (opc == OPC_RTI) begin
					pc_d = word;
					state_d = EX_RD3;
				end else if (opc == OPC_TRAP) begin
					rf_we = 1'b1;
					rf_wi = 3'd7;
					rf_wd = pc_q;
					wrk_d.dest_written = 1'b1;
					wrk_d.dest_index = 3'd7;
					wrk_d.dest_value = pc_q;
					pc_d = word;
				end else begin
					rf_we = 1'b1;
					rf_wd = word;
					cc_d = nzp_of(word);
					wrk_d.dest_written = 1'b1;
					wrk_d.dest_index = dr;
					wrk_d.dest_value = word;
				end
			end
			EX_RD3: begin
				// low psr byte arrives; high byte is taken in a second pass of EX_RD2
				mem_ra = ea_q + 16'd3;
				lo_d = rdat;
				rti_ph_d = 1'b1;
				state_d = EX_RD2;
			end
			EX_DONE: if (can_out) begin
				rsp_load = 1'b1;
				state_d = EX_IDLE;
			end
			default: state_d = EX_IDLE;
		endcase
	end

	// Response assembled from working fields and architectural state
	always_comb begin
		done_rsp = wrk_q;
		done_rsp.new_pc = pc_q;
		done_rsp.cond_n = cc_q[2];
		done_rsp.cond_z = cc_q[1];
		done_rsp.cond_p = cc_q[0];
		done_rsp.user_mode = priv_q;
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EX_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= 16'd0;
			cc_q <= 3'b010;
			priv_q <= 1'b0;
			rti_ph_q <= 1'b0;
			for (int i = 0; i < 8; i++) rf_q[i] <= 16'd0;
		end else begin
			pc_q <= pc_d;
			cc_q <= cc_d;
			priv_q <= priv_d;
			rti_ph_q <= rti_ph_d;
			if (rf_we) rf_q[rf_wi] <= rf_wd;
		end
	end

	// Working registers of the request in flight
	always_ff @(posedge clk) begin
		if (state_q == EX_IDLE && req_valid) cur_q <= req;
		ea_q <= ea_d;
		lo_q <= lo_d;
		wrk_q <= wrk_d;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_full_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_full_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) rsp <= done_rsp;
	end
endmodule

// ===== rtl/lc3b_instruction_execute_top.sv =====
// LC-3b execute unit: 2-entry request queue feeding a multi-cycle executer.
// Requests run one at a time: a new one is taken only once the last result is loaded for output;
// the byte memory has one read port and one write port (one byte read per cycle).
// Reset: registers and PC zero, Z flag set, supervisor mode; memory undefined until written.
// Depends on lc3b_pkg, lc3b_queue, lc3b_exec.
module lc3b_instruction_execute_top import lc3b_pkg::*; #(
	parameter int MEM_BYTES = 65536
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output rsp_t out_data
);
	logic q_valid, q_ready;
	req_t q_req;

	lc3b_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_req(in_data),
		.out_valid(q_valid), .out_ready(q_ready), .out_req(q_req)
	);

	lc3b_exec #(.MEM_BYTES(MEM_BYTES)) u_exec (
		.clk(clk), .arst_n(arst_n),
		.req_valid(q_valid), .req_ready(q_ready), .req(q_req),
		.rsp_valid(out_valid), .rsp_ready(out_ready), .rsp(out_data)
	);
endmodule

// ===== verif/lc3b_instruction_execute_top_test.sv =====
// Testbench for lc3b_instruction_execute_top: directed and random LC-3b requests,
// checked against an in-bench model of the execute unit. Depends on lc3b_pkg.
module lc3b_instruction_execute_top_test;
	import lc3b_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid = 1'b0;
	logic in_ready;
	req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rsp_t out_data;

	lc3b_instruction_execute_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// model state
	logic [15:0] cpu_regs [8];
	logic [15:0] cpu_pc;
	logic [2:0] cpu_nzp;
	logic cpu_user;
	logic [7:0] cpu_mem [int];

	req_t pending_reqs [$];
	rsp_t expected_rsps [$];
	int mismatches = 0;
	int cycle_count = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// key of a byte address, wrapped to 16 bits
	function automatic int mem_key(logic [15:0] a);
		return int'(a);
	endfunction

	function automatic logic [15:0] sign_ext(logic [15:0] v, int bits);
		logic [15:0] r;
		r = v;
		for (int i = bits; i < 16; i++) r[i] = v[bits-1];
		return r;
	endfunction

	function automatic logic [7:0] mem_byte(logic [15:0] a);
		return cpu_mem.exists(mem_key(a)) ? cpu_mem[mem_key(a)] : 8'h00;
	endfunction

	function automatic logic [15:0] mem_word(logic [15:0] a);
		return {mem_byte(a + 16'd1), mem_byte(a)};
	endfunction

	function automatic logic [2:0] nzp_of(logic [15:0] v);
		if (v[15]) return 3'b100;
		if (v == 0) return 3'b010;
		return 3'b001;
	endfunction

	// Advance the model by one request and return the expected response
	function automatic rsp_t execute_req(req_t rq);
		rsp_t r;
		logic [15:0] ir, a, b, ea, dv, sp, psr, tgt;
		logic [3:0] opc;
		logic [2:0] dr;
		logic wr;
		logic [31:0] sv;
		r = '0;
		ir = rq.instruction;
		wr = 0;
		dv = 0;
		dr = 0;
		case (oper_t'(rq.operation))
			OP_WRMEM: cpu_mem[mem_key(rq.mem_address)] = rq.mem_data;
			OP_RDMEM: r.read_data = mem_byte(rq.mem_address);
			OP_SETPC: cpu_pc = rq.mem_address;
			default: begin
				opc = ir[15:12];
				a = cpu_regs[ir[8:6]];
				b = ir[5] ? sign_ext(ir, 5) : cpu_regs[ir[2:0]];
				cpu_pc = cpu_pc + 16'd2;
				case (opc)
					OPC_BR: begin
						if (ir[11:9] & cpu_nzp) cpu_pc = cpu_pc + (sign_ext(ir, 9) << 1);
					end
					OPC_ADD: begin wr = 1; dr = ir[11:9]; dv = a + b; end
					OPC_AND: begin wr = 1; dr = ir[11:9]; dv = a & b; end
					OPC_XOR: begin wr = 1; dr = ir[11:9]; dv = a ^ b; end
					OPC_LDB: begin
						ea = a + sign_ext(ir, 6);
						wr = 1; dr = ir[11:9]; dv = sign_ext({8'h00, mem_byte(ea)}, 8);
					end
					OPC_LDW: begin
						ea = a + (sign_ext(ir, 6) << 1);
						wr = 1; dr = ir[11:9]; dv = mem_word(ea);
					end
					OPC_STB: begin
						ea = a + sign_ext(ir, 6);
						cpu_mem[mem_key(ea)] = cpu_regs[ir[11:9]][7:0];
					end
					OPC_STW: begin
						ea = a + (sign_ext(ir, 6) << 1);
						cpu_mem[mem_key(ea)] = cpu_regs[ir[11:9]][7:0];
						cpu_mem[mem_key(ea + 16'd1)] = cpu_regs[ir[11:9]][15:8];
					end
					OPC_JSR: begin
						ea = ir[11] ? cpu_pc + (sign_ext(ir, 11) << 1) : a;
						cpu_regs[7] = cpu_pc;
						wr = 1; dr = 3'd7; dv = cpu_pc;
						cpu_pc = ea;
					end
					OPC_RTI: begin
						if (cpu_user) r.status = ST_PRIV;
						else begin
							sp = cpu_regs[6];
							cpu_pc = mem_word(sp);
							sp = sp + 16'd2;
							psr = mem_word(sp);
							sp = sp + 16'd2;
							cpu_regs[6] = sp;
							cpu_user = psr[15];
							cpu_nzp = psr[2:0];
							wr = 1; dr = 3'd6; dv = sp;
						end
					end
					OPC_RES_A, OPC_RES_B: r.status = ST_RSVD;
					OPC_JMP: cpu_pc = a;
					OPC_SHF: begin
						if (ir[4]) begin
							if (ir[5] && a[15]) sv = {16'hFFFF, a} >> ir[3:0];
							else sv = {16'h0, a} >> ir[3:0];
						end else sv = {16'h0, a} << ir[3:0];
						wr = 1; dr = ir[11:9]; dv = sv[15:0];
					end
					OPC_LEA: begin
						wr = 1; dr = ir[11:9]; dv = cpu_pc + (sign_ext(ir, 9) << 1);
					end
					default: begin
						tgt = mem_word({7'd0, ir[7:0], 1'b0});
						cpu_regs[7] = cpu_pc;
						wr = 1; dr = 3'd7; dv = cpu_pc;
						cpu_pc = tgt;
					end
				endcase
				if (wr && opc != OPC_JSR && opc != OPC_TRAP && opc != OPC_RTI) begin
					cpu_regs[dr] = dv;
					cpu_nzp = nzp_of(dv);
				end
			end
		endcase
		r.new_pc = cpu_pc;
		r.dest_written = wr;
		r.dest_index = dr;
		r.dest_value = dv;
		{r.cond_n, r.cond_z, r.cond_p} = cpu_nzp;
		r.user_mode = cpu_user;
		return r;
	endfunction

	// Base of the data area the random stream fills; any load, trap or RTI reads only written bytes
	localparam int DATA_BASE = 16'h4000;

	function automatic req_t make_req(oper_t op, logic [15:0] ir, logic [15:0] ad, logic [7:0] d);
		req_t q;
		q.operation = op;
		q.instruction = ir;
		q.mem_address = ad;
		q.mem_data = d;
		return q;
	endfunction

	task automatic push_req(req_t q);
		pending_reqs.push_back(q);
	endtask

	// bytes written so far by the generated stream
	bit gen_written [int];

	task automatic gen_wrbyte(logic [15:0] ad, logic [7:0] d);
		push_req(make_req(OP_WRMEM, 16'h0, ad, d));
		gen_written[mem_key(ad)] = 1;
	endtask

	// True when n bytes from ea have all been written
	function automatic logic ea_ok(logic [15:0] ea, int n);
		for (int i = 0; i < n; i++) if (!gen_written.exists(mem_key(ea + i[15:0]))) return 0;
		return 1;
	endfunction

	initial begin
		req_t q;
		logic [15:0] ir, ea;
		logic [3:0] opc;
		arst_n = 0;
		for (int i = 0; i < 8; i++) cpu_regs[i] = 0;
		cpu_pc = 0;
		cpu_nzp = 3'b010;
		cpu_user = 0;
		// fill base area so loads from it are legal
		for (int i = 0; i < 64; i++) gen_wrbyte(DATA_BASE[15:0] + i[15:0], 8'($urandom));
		// trap vector 0 used by the directed part
		gen_wrbyte(16'h0000, 8'h00);
		gen_wrbyte(16'h0001, 8'h00);
		// directed part
		push_req(make_req(OP_RDMEM, 16'h0, DATA_BASE[15:0], 8'h0));
		push_req(make_req(OP_WRMEM, 16'h0, 16'hFFFF, 8'hFF));
		push_req(make_req(OP_RDMEM, 16'h0, 16'hFFFF, 8'h0));
		gen_written[16'hFFFF] = 1;
		push_req(make_req(OP_SETPC, 16'h0, 16'hFFFE, 8'h0));
		push_req(make_req(OP_EXEC, {OPC_ADD, 3'd1, 3'd0, 1'b1, 5'h0F}, 16'h0, 8'h0));
		push_req(make_req(OP_EXEC, {OPC_ADD, 3'd2, 3'd0, 1'b1, 5'h10}, 16'h0, 8'h0));
		push_req(make_req(OP_EXEC, {OPC_ADD, 3'd3, 3'd1, 3'b000, 3'd2}, 16'h0, 8'h0));
		push_req(make_req(OP_EXEC, {OPC_AND, 3'd4, 3'd2, 1'b1, 5'h1F}, 16'h0, 8'h0));
		push_req(make_req(OP_EXEC, {OPC_XOR, 3'd5, 3'd2, 1'b1, 5'h1F}, 16'h0, 8'h0));
		push_req(make_req(OP_EXEC, {OPC_SHF, 3'd5, 3'd2, 2'b11, 4'd15}, 16'h0, 8'h0));
		push_req(make_req(OP_EXEC, {OPC_SHF, 3'd5, 3'd2, 2'b01, 4'd3}, 16'h0, 8'h0));
		push_req(make_req(OP_EXEC, {OPC_SHF, 3'd5, 3'd1, 2'b10, 4'd15}, 16'h0, 8'h0));
		push_req(make_req(OP_EXEC, {OPC_BR, 3'b000, 9'h1FF}, 16'h0, 8'h0));
		push_req(make_req(OP_EXEC, {OPC_BR, 3'b111, 9'h100}, 16'h0, 8'h0));
		push_req(make_req(OP_EXEC, {OPC_LEA, 3'd6, 9'h0FF}, 16'h0, 8'h0));
		push_req(make_req(OP_EXEC, {OPC_RES_A, 12'hFFF}, 16'h0, 8'h0));
		push_req(make_req(OP_EXEC, {OPC_RES_B, 12'h000}, 16'h0, 8'h0));
		push_req(make_req(OP_EXEC, {OPC_JSR, 1'b1, 11'h7FF}, 16'h0, 8'h0));
		push_req(make_req(OP_EXEC, {OPC_JSR, 3'b000, 3'd7, 6'd0}, 16'h0, 8'h0));
		push_req(make_req(OP_EXEC, {OPC_JMP, 3'b000, 3'd1, 6'd0}, 16'h0, 8'h0));
		push_req(make_req(OP_EXEC, {OPC_TRAP, 4'd0, 8'h00}, 16'h0, 8'h0));
		// The random stream: run the model as a shadow to choose legal addresses,
		// then restore state before the run.
		begin
			rsp_t dummy;
			foreach (pending_reqs[i]) dummy = execute_req(pending_reqs[i]);
			while (pending_reqs.size() < 1150) begin
				opc = 4'($urandom_range(0, 15));
				ir = 16'($urandom);
				ir[15:12] = opc;
				q = make_req(OP_EXEC, ir, 16'h0, 8'h0);
				case ($urandom_range(0, 9))
					0: q = make_req(OP_WRMEM, 16'h0, 16'(DATA_BASE + $urandom_range(0, 63)),
						8'($urandom));
					1: q = make_req(OP_RDMEM, 16'h0, 16'(DATA_BASE + $urandom_range(0, 63)), 8'h0);
					2: q = make_req(OP_SETPC, 16'h0, 16'($urandom), 8'h0);
					3: begin
						// point a base register at the data area: SETPC then LEA
						q = make_req(OP_SETPC, 16'h0, DATA_BASE[15:0] + 16'h40, 8'h0);
						pending_reqs.push_back(q);
						dummy = execute_req(q);
						q = make_req(OP_EXEC, {OPC_LEA, 3'($urandom_range(0, 7)),
							9'h1E0 + 9'($urandom_range(0, 8))}, 16'h0, 8'h0);
					end
					4: begin
						// supervisor RTI: build stack at data area in R6
						q = make_req(OP_SETPC, 16'h0, DATA_BASE[15:0] + 16'h22, 8'h0);
						pending_reqs.push_back(q);
						dummy = execute_req(q);
						q = make_req(OP_EXEC, {OPC_LEA, 3'd6, 9'h1F0}, 16'h0, 8'h0);
						pending_reqs.push_back(q);
						dummy = execute_req(q);
						q = make_req(OP_EXEC, {OPC_RTI, 12'h0}, 16'h0, 8'h0);
					end
					default: ;
				endcase
				// legality of memory reads under the shadow state
				if (q.operation == OP_EXEC) begin
					ir = q.instruction;
					case (ir[15:12])
						OPC_LDB: if (!ea_ok(cpu_regs[ir[8:6]] + sign_ext(ir, 6), 1)) continue;
						OPC_LDW: if (!ea_ok(cpu_regs[ir[8:6]] + (sign_ext(ir, 6) << 1), 2)) continue;
						OPC_TRAP: if (!ea_ok({7'd0, ir[7:0], 1'b0}, 2)) begin
							// make the vector legal by writing it first
							gen_wrbyte({7'd0, ir[7:0], 1'b0}, 8'($urandom));
							gen_wrbyte({7'd0, ir[7:0], 1'b1}, 8'($urandom));
							dummy = execute_req(pending_reqs[$-1]);
							dummy = execute_req(pending_reqs[$]);
						end
						OPC_RTI: if (!cpu_user && !ea_ok(cpu_regs[6], 4)) continue;
						default: ;
					endcase
				end
				if (q.operation == OP_RDMEM && !gen_written.exists(mem_key(q.mem_address))) continue;
				if (q.operation == OP_WRMEM) gen_written[mem_key(q.mem_address)] = 1;
				if (q.operation == OP_EXEC && q.instruction[15:12] == OPC_STB)
					gen_written[mem_key(cpu_regs[q.instruction[8:6]] + sign_ext(q.instruction, 6))] = 1;
				if (q.operation == OP_EXEC && q.instruction[15:12] == OPC_STW) begin
					ea = cpu_regs[q.instruction[8:6]] + (sign_ext(q.instruction, 6) << 1);
					gen_written[mem_key(ea)] = 1;
					gen_written[mem_key(ea + 16'd1)] = 1;
				end
				pending_reqs.push_back(q);
				dummy = execute_req(q);
			end
			// reset the model for the live run
			for (int i = 0; i < 8; i++) cpu_regs[i] = 0;
			cpu_pc = 0;
			cpu_nzp = 3'b010;
			cpu_user = 0;
			cpu_mem.delete();
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	// driver: bursts with random gaps
	int burst_left = 0;
	int gap_left = 0;
	int sent_count = 0;
	int accept_count = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || accept_count == sent_count) begin
				if (pending_reqs.size() > 0 && gap_left == 0) begin
					in_valid <= 1;
					in_data <= pending_reqs.pop_front();
					sent_count++;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 20);
					end
					burst_left--;
					if (burst_left == 0) gap_left = $urandom_range(0, 1) ? $urandom_range(1, 12) : 0;
				end else begin
					in_valid <= 0;
					if (gap_left > 0) gap_left--;
				end
			end
		end
	end

	// receiver stall pattern, with one long hold-off
	int stall_phase = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			stall_phase <= stall_phase + 1;
			if (cycle_count > 2000 && cycle_count < 2300) out_ready <= 0;
			else if ((stall_phase / 400) % 2 == 0) out_ready <= 1;
			else out_ready <= ($urandom_range(0, 3) != 0) && (stall_phase % 7 != 3);
		end
	end

	// input acceptance feeds the model; responses are checked against it in order
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count <= cycle_count + 1;
			if (in_valid && in_ready) begin
				expected_rsps.push_back(execute_req(in_data));
				accept_count++;
			end
			if (out_valid && out_ready) begin
				if (expected_rsps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected response %p", out_data);
				end else begin
					if (out_data !== expected_rsps[0]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p actual %p", expected_rsps[0], out_data);
					end
					expected_rsps.pop_front();
				end
			end
		end
	end

	// end of run
	initial begin
		wait (arst_n);
		while (!(pending_reqs.size() == 0 && !in_valid && expected_rsps.size() == 0)
			&& cycle_count < 200000)
			@(posedge clk);
		if (cycle_count >= 200000) begin
			$display("FAIL");
		end else begin
			repeat (20) @(posedge clk);
			if (mismatches == 0 && expected_rsps.size() == 0) $display("PASS");
			else $display("FAIL");
		end
		$finish;
	end

endmodule

// ===== lc3b_instruction_execute_top.f =====
rtl/lc3b_pkg.sv
rtl/lc3b_queue.sv
rtl/lc3b_exec.sv
rtl/lc3b_instruction_execute_top.sv
verif/lc3b_instruction_execute_top_test.sv
